FILE: sv/s2ok_pkg.sv
`timescale 1ns / 1ps

package s2ok_pkg;

	localparam int VAL_W = 28;
	localparam int LIN_W = 25;
	localparam int COEF_W = 16;
	localparam int ANG_W = 27;
	localparam int XY_W = 32;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [LIN_W-1:0] lin_tab_t [256];
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t coef_mat_t [9];

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [15:0] lightness;
		logic [14:0] chroma;
		logic [14:0] hue;
	} oklch_t;

	localparam coef_mat_t M_XYZ = '{
		16'sd4124, 16'sd3576, 16'sd1805,
		16'sd2126, 16'sd7152, 16'sd722,
		16'sd193, 16'sd1192, 16'sd9505
	};
	localparam coef_mat_t M_LMS = '{
		16'sd8189, 16'sd3618, -16'sd1288,
		16'sd329, 16'sd9293, 16'sd361,
		16'sd486, 16'sd2621, 16'sd6839
	};
	localparam coef_mat_t M_LAB = '{
		16'sd2104, 16'sd7936, -16'sd40,
		16'sd19779, -16'sd24285, 16'sd4506,
		16'sd259, 16'sd7827, -16'sd8086
	};

	// floor(p / 625) = (p * DIV_M) >> 46 for p < 2^36
	localparam longint unsigned DIV_M = ((64'd1 << 46) + 64'd624) / 64'd625;
	localparam logic [18:0] DIV_MH = 19'(DIV_M >> 18);
	localparam logic [17:0] DIV_ML = 18'(DIV_M);

	localparam logic [21:0] ATAN_Q16 [16] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379, 22'd117266, 22'd58666, 22'd29335,
		22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115
	};
	localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
	localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;

	localparam int MAT_LAT = 4;
	localparam int CBRT_LAT = 56;
	localparam int SQRT_LAT = 31;
	localparam int HUE_LAT = 18;

	function automatic longint qmul(longint x, longint y);
		return (x * y) >>> 24;
	endfunction

	function automatic longint pow5(longint y);
		longint p;
		p = qmul(y, y);
		p = qmul(p, y);
		p = qmul(p, y);
		return qmul(p, y);
	endfunction

	function automatic lin_tab_t build_lin_tab();
		lin_tab_t tab;
		longint v;
		longint t;
		longint u;
		longint r;
		longint c;
		for (int b = 0; b < 256; b++) begin
			v = (longint'(b) * (64'sd1 <<< 24) + 64'sd127) / 64'sd255;
			if (b <= 10) begin
				tab[b] = LIN_W'(v * 64'sd100 / 64'sd1292);
			end else begin
				t = (v + 64'sd922747) * 64'sd1000 / 64'sd1055;
				u = qmul(t, t);
				r = 0;
				for (int k = 24; k >= 0; k--) begin
					c = r | (64'sd1 <<< k);
					if (pow5(c) <= u) begin
						r = c;
					end
				end
				tab[b] = LIN_W'(qmul(u, r));
			end
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

FILE: sv/srgb_to_oklch_converter_top.sv
`timescale 1ns / 1ps

// sRGB to OKLCH converter. A request (start high, busy low) takes one sRGB
// pixel of 8-bit channels; busy is always low, so a pixel can enter on every
// clock. Each pixel comes out with a one-cycle done strobe after the gamma
// table register, three matrix units, a cube root with a trial and a compare
// register per root bit, and the chroma square root. Hue runs beside the
// square root. The result must be taken in the done cycle; there is no holding it off.
module srgb_to_oklch_converter_top import s2ok_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  pixel_t pixel,
	output logic done,
	output oklch_t color
);

	localparam int HUE_PAD = SQRT_LAT - HUE_LAT;

	val_t lin_s1 [3];
	logic vld_s1;

	val_t xyz [3];
	val_t lms [3];
	val_t lp [3];
	val_t lab [3];
	logic xyz_vld, lms_vld, lp_vld, lab_vld;

	logic [15:0] l_s [SQRT_LAT];
	logic [14:0] h_s [HUE_PAD];
	logic [14:0] chroma;
	logic [14:0] hue;
	logic signed [19:0] l_shift;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		lin_s1[0] <= VAL_W'(LIN_TAB[pixel.red]);
		lin_s1[1] <= VAL_W'(LIN_TAB[pixel.green]);
		lin_s1[2] <= VAL_W'(LIN_TAB[pixel.blue]);
	end

	s2ok_mat #(.COEF(M_XYZ)) u_xyz (
		.clk(clk), .arst_n(arst_n),
		.a_vld(vld_s1), .a(lin_s1),
		.y_vld(xyz_vld), .y(xyz)
	);

	s2ok_mat #(.COEF(M_LMS)) u_lms (
		.clk(clk), .arst_n(arst_n),
		.a_vld(xyz_vld), .a(xyz),
		.y_vld(lms_vld), .y(lms)
	);

	s2ok_cbrt u_cbrt0 (
		.clk(clk), .arst_n(arst_n),
		.a_vld(lms_vld), .a(lms[0]),
		.y_vld(lp_vld), .y(lp[0])
	);

	s2ok_cbrt u_cbrt1 (
		.clk(clk), .arst_n(arst_n),
		.a_vld(lms_vld), .a(lms[1]),
		.y_vld(), .y(lp[1])
	);

	s2ok_cbrt u_cbrt2 (
		.clk(clk), .arst_n(arst_n),
		.a_vld(lms_vld), .a(lms[2]),
		.y_vld(), .y(lp[2])
	);

	s2ok_mat #(.COEF(M_LAB)) u_lab (
		.clk(clk), .arst_n(arst_n),
		.a_vld(lp_vld), .a(lp),
		.y_vld(lab_vld), .y(lab)
	);

	s2ok_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.a_vld(lab_vld), .a(lab[1]), .b(lab[2]),
		.y_vld(done), .y(chroma)
	);

	s2ok_cordic u_hue (
		.clk(clk),
		.a(lab[1]), .b(lab[2]),
		.y(hue)
	);

	assign l_shift = 20'(lab[0] >>> 8);

	always_ff @(posedge clk) begin
		if (l_shift < 0) begin
			l_s[0] <= '0;
		end else if (l_shift > 20'sd65535) begin
			l_s[0] <= 16'hffff;
		end else begin
			l_s[0] <= l_shift[15:0];
		end
		for (int k = 1; k < SQRT_LAT; k++) begin
			l_s[k] <= l_s[k-1];
		end
		h_s[0] <= hue;
		for (int k = 1; k < HUE_PAD; k++) begin
			h_s[k] <= h_s[k-1];
		end
	end

	assign color.lightness = l_s[SQRT_LAT-1];
	assign color.chroma = chroma;
	assign color.hue = h_s[HUE_PAD-1];

endmodule

FILE: sv/s2ok_mat.sv
`timescale 1ns / 1ps

module s2ok_mat import s2ok_pkg::*; #(
	parameter coef_mat_t COEF = M_XYZ
) (
	input  logic clk,
	input  logic arst_n,
	input  logic a_vld,
	input  val_t a [3],
	output logic y_vld,
	output val_t y [3]
);

	logic signed [43:0] prod_s1 [9];
	logic [39:0] mag_s2 [3];
	logic neg_s2 [3];
	logic [36:0] hh_s3 [3];
	logic [36:0] hl_s3 [3];
	logic [36:0] lh_s3 [3];
	logic [36:0] ll_s3 [3];
	logic neg_s3 [3];
	logic vld_s1, vld_s2, vld_s3;

	logic signed [45:0] sum [3];
	logic [75:0] qfull [3];
	val_t quot [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			y_vld <= 1'b0;
		end else begin
			vld_s1 <= a_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			y_vld <= vld_s3;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = 46'(prod_s1[3*r]) + 46'(prod_s1[3*r+1]) + 46'(prod_s1[3*r+2]);
			qfull[r] = ((76'(hh_s3[r]) << 36) + (76'(hl_s3[r]) << 18)
				+ (76'(lh_s3[r]) << 18) + 76'(ll_s3[r])) >> 46;
			quot[r] = VAL_W'(qfull[r]);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[3*r+c] <= 44'(a[c]) * 44'(COEF[3*r+c]);
			end
			neg_s2[r] <= sum[r] < 0;
			mag_s2[r] <= 40'((sum[r] < 0) ? -sum[r] : sum[r]);
			neg_s3[r] <= neg_s2[r];
			hh_s3[r] <= 37'(mag_s2[r][39:22]) * 37'(DIV_MH);
			hl_s3[r] <= 37'(mag_s2[r][39:22]) * 37'(DIV_ML);
			lh_s3[r] <= 37'(mag_s2[r][21:4]) * 37'(DIV_MH);
			ll_s3[r] <= 37'(mag_s2[r][21:4]) * 37'(DIV_ML);
			y[r] <= neg_s3[r] ? -quot[r] : quot[r];
		end
	end

endmodule

FILE: sv/s2ok_cbrt.sv
`timescale 1ns / 1ps

module s2ok_cbrt import s2ok_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic a_vld,
	input  val_t a,
	output logic y_vld,
	output val_t y
);

	localparam int NB = 27;

	logic [VAL_W-1:0] mag_s0;
	logic neg_s0;
	logic vld_s0;

	logic [NB-1:0] c_sa [NB];
	logic [29:0] sq_sa [NB];
	logic [VAL_W-1:0] m_sa [NB];
	logic neg_sa [NB];
	logic vld_sa [NB];
	logic [NB-1:0] r_sb [NB];
	logic [VAL_W-1:0] m_sb [NB];
	logic neg_sb [NB];
	logic vld_sb [NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			y_vld <= 1'b0;
		end else begin
			vld_s0 <= a_vld;
			y_vld <= vld_sb[NB-1];
		end
	end

	always_ff @(posedge clk) begin
		neg_s0 <= a < 0;
		mag_s0 <= VAL_W'((a < 0) ? -a : a);
		y <= neg_sb[NB-1] ? -VAL_W'(r_sb[NB-1]) : VAL_W'(r_sb[NB-1]);
	end

	for (genvar j = 0; j < NB; j++) begin : g_bit
		localparam logic [NB-1:0] BIT = NB'(1) << (NB - 1 - j);
		logic [NB-1:0] r_in;
		logic [VAL_W-1:0] m_in;
		logic neg_in;
		logic vld_in;
		logic [NB-1:0] cand;
		logic [53:0] sq_full;
		logic [56:0] cube_full;

		if (j == 0) begin : g_first
			assign r_in = '0;
			assign m_in = mag_s0;
			assign neg_in = neg_s0;
			assign vld_in = vld_s0;
		end else begin : g_next
			assign r_in = r_sb[j-1];
			assign m_in = m_sb[j-1];
			assign neg_in = neg_sb[j-1];
			assign vld_in = vld_sb[j-1];
		end

		assign cand = r_in | BIT;
		assign sq_full = 54'(cand) * 54'(cand);
		assign cube_full = 57'(sq_sa[j]) * 57'(c_sa[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sa[j] <= 1'b0;
				vld_sb[j] <= 1'b0;
			end else begin
				vld_sa[j] <= vld_in;
				vld_sb[j] <= vld_sa[j];
			end
		end

		always_ff @(posedge clk) begin
			c_sa[j] <= cand;
			sq_sa[j] <= 30'(sq_full >> 24);
			m_sa[j] <= m_in;
			neg_sa[j] <= neg_in;
			r_sb[j] <= (33'(cube_full >> 24) <= 33'(m_sa[j])) ? c_sa[j] : (c_sa[j] & ~BIT);
			m_sb[j] <= m_sa[j];
			neg_sb[j] <= neg_sa[j];
		end
	end

endmodule

FILE: sv/s2ok_sqrt.sv
`timescale 1ns / 1ps

module s2ok_sqrt import s2ok_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic a_vld,
	input  val_t a,
	input  val_t b,
	output logic y_vld,
	output logic [14:0] y
);

	localparam int NS = 28;

	logic [55:0] aa_s1, bb_s1;
	logic [55:0] n_s2;
	logic vld_s1, vld_s2;

	logic [30:0] rem_s [NS];
	logic [NS-1:0] root_s [NS];
	logic [55:0] n_s [NS];
	logic vld_s [NS];

	logic [19:0] c16;

	assign c16 = root_s[NS-1][NS-1:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			y_vld <= 1'b0;
		end else begin
			vld_s1 <= a_vld;
			vld_s2 <= vld_s1;
			y_vld <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		aa_s1 <= 56'(a) * 56'(a);
		bb_s1 <= 56'(b) * 56'(b);
		n_s2 <= aa_s1 + bb_s1;
		y <= (c16 > 20'd32767) ? 15'h7fff : c16[14:0];
	end

	for (genvar k = 0; k < NS; k++) begin : g_step
		localparam int P = NS - 1 - k;
		logic [30:0] rem_in;
		logic [NS-1:0] root_in;
		logic [55:0] n_in;
		logic vld_in;
		logic [30:0] remx;
		logic [30:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign n_in = n_s2;
			assign vld_in = vld_s2;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign n_in = n_s[k-1];
			assign vld_in = vld_s[k-1];
		end

		assign remx = {rem_in[28:0], n_in[2*P+1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			n_s[k] <= n_in;
			if (remx >= trial) begin
				rem_s[k] <= remx - trial;
				root_s[k] <= {root_in[NS-2:0], 1'b1};
			end else begin
				rem_s[k] <= remx;
				root_s[k] <= {root_in[NS-2:0], 1'b0};
			end
		end
	end

endmodule

FILE: sv/s2ok_cordic.sv
`timescale 1ns / 1ps

module s2ok_cordic import s2ok_pkg::*; (
	input  logic clk,
	input  val_t a,
	input  val_t b,
	output logic [14:0] y
);

	localparam int NI = 16;

	logic signed [XY_W-1:0] x_s0, y_s0;
	logic signed [ANG_W-1:0] ang_s0;
	logic zero_s0;

	logic signed [XY_W-1:0] x_s [NI];
	logic signed [XY_W-1:0] y_s [NI];
	logic signed [ANG_W-1:0] ang_s [NI];
	logic zero_s [NI];

	logic signed [ANG_W-1:0] w1, w2;

	always_comb begin
		w1 = (ang_s[NI-1] < 0) ? ang_s[NI-1] + DEG360 : ang_s[NI-1];
		w2 = (w1 >= DEG360) ? w1 - DEG360 : w1;
	end

	always_ff @(posedge clk) begin
		zero_s0 <= (a == '0) && (b == '0);
		if (a < 0) begin
			x_s0 <= -XY_W'(a);
			y_s0 <= -XY_W'(b);
			ang_s0 <= DEG180;
		end else begin
			x_s0 <= XY_W'(a);
			y_s0 <= XY_W'(b);
			ang_s0 <= '0;
		end
		y <= zero_s[NI-1] ? '0 : w2[24:10];
	end

	for (genvar i = 0; i < NI; i++) begin : g_iter
		localparam logic signed [ANG_W-1:0] STEP = ANG_W'(ATAN_Q16[i]);
		logic signed [XY_W-1:0] x_in, y_in;
		logic signed [ANG_W-1:0] ang_in;
		logic zero_in;

		if (i == 0) begin : g_first
			assign x_in = x_s0;
			assign y_in = y_s0;
			assign ang_in = ang_s0;
			assign zero_in = zero_s0;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign y_in = y_s[i-1];
			assign ang_in = ang_s[i-1];
			assign zero_in = zero_s[i-1];
		end

		always_ff @(posedge clk) begin
			zero_s[i] <= zero_in;
			if (y_in > 0) begin
				x_s[i] <= x_in + (y_in >>> i);
				y_s[i] <= y_in - (x_in >>> i);
				ang_s[i] <= ang_in + STEP;
			end else begin
				x_s[i] <= x_in - (y_in >>> i);
				y_s[i] <= y_in + (x_in >>> i);
				ang_s[i] <= ang_in - STEP;
			end
		end
	end

endmodule

FILE: tb/srgb_to_oklch_converter_checker.sv
`timescale 1ns / 1ps

module srgb_to_oklch_converter_checker import s2ok_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  pixel_t pixel,
	input  logic done,
	input  oklch_t color,
	output int errors,
	output int pending
);

	oklch_t color_q[$];

	localparam longint XYZ_C [9] = '{4124, 3576, 1805, 2126, 7152, 722, 193, 1192, 9505};
	localparam longint LMS_C [9] = '{8189, 3618, -1288, 329, 9293, 361, 486, 2621, 6839};
	localparam longint LAB_C [9] = '{2104, 7936, -40, 19779, -24285, 4506, 259, 7827, -8086};
	localparam longint ATAN_TAB [16] = '{2949120, 1740967, 919879, 466945, 234379, 117266,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	function automatic longint fx_mul(longint x, longint y);
		return (x * y) >>> 24;
	endfunction

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint linearize(int unsigned b);
		longint v;
		longint t;
		longint u;
		longint r;
		longint c;
		longint p;
		v = (longint'(b) * (64'sd1 <<< 24) + 127) / 255;
		if (b <= 10) begin
			return v * 100 / 1292;
		end
		t = (v + 922747) * 1000 / 1055;
		u = fx_mul(t, t);
		r = 0;
		for (int k = 24; k >= 0; k--) begin
			c = r | (64'sd1 <<< k);
			p = fx_mul(fx_mul(fx_mul(fx_mul(c, c), c), c), c);
			if (p <= u) begin
				r = c;
			end
		end
		return fx_mul(u, r);
	endfunction

	function automatic longint cube_root(longint x);
		longint m;
		longint r;
		longint c;
		m = x < 0 ? -x : x;
		r = 0;
		for (int k = 26; k >= 0; k--) begin
			c = r | (64'sd1 <<< k);
			if (fx_mul(fx_mul(c, c), c) <= m) begin
				r = c;
			end
		end
		return x < 0 ? -r : r;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > n) begin
			bt >>= 2;
		end
		while (bt != 0) begin
			if (n >= res + bt) begin
				n -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic longint hue_angle(longint a, longint b);
		longint x;
		longint y;
		longint ang;
		longint dx;
		longint dy;
		if (a == 0 && b == 0) begin
			return 0;
		end
		x = a;
		y = b;
		ang = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			ang = 180 <<< 16;
		end
		for (int i = 0; i < 16; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (y > 0) begin
				x += dx;
				y -= dy;
				ang += ATAN_TAB[i];
			end else begin
				x -= dx;
				y += dy;
				ang -= ATAN_TAB[i];
			end
		end
		if (ang < 0) begin
			ang += 23592960;
		end
		if (ang >= 23592960) begin
			ang -= 23592960;
		end
		return ang >>> 10;
	endfunction

	function automatic oklch_t convert_pixel(pixel_t px);
		longint lin [3];
		longint xyz [3];
		longint lms [3];
		longint lp [3];
		longint lab [3];
		longint l16;
		longint unsigned c16;
		oklch_t res;
		lin[0] = linearize(px.red);
		lin[1] = linearize(px.green);
		lin[2] = linearize(px.blue);
		for (int r = 0; r < 3; r++) begin
			xyz[r] = (XYZ_C[3*r] * lin[0] + XYZ_C[3*r+1] * lin[1] + XYZ_C[3*r+2] * lin[2]) / 10000;
		end
		for (int r = 0; r < 3; r++) begin
			lms[r] = (LMS_C[3*r] * xyz[0] + LMS_C[3*r+1] * xyz[1] + LMS_C[3*r+2] * xyz[2]) / 10000;
		end
		for (int r = 0; r < 3; r++) begin
			lp[r] = cube_root(lms[r]);
		end
		for (int r = 0; r < 3; r++) begin
			lab[r] = (LAB_C[3*r] * lp[0] + LAB_C[3*r+1] * lp[1] + LAB_C[3*r+2] * lp[2]) / 10000;
		end
		l16 = floor_shr(lab[0], 8);
		if (l16 < 0) begin
			l16 = 0;
		end
		if (l16 > 65535) begin
			l16 = 65535;
		end
		c16 = int_sqrt(longint'(lab[1] * lab[1]) + longint'(lab[2] * lab[2])) >> 8;
		if (c16 > 32767) begin
			c16 = 32767;
		end
		res.lightness = 16'(l16);
		res.chroma = 15'(c16);
		res.hue = 15'(hue_angle(lab[1], lab[2]));
		return res;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
	end

	assign pending = color_q.size();

	always @(posedge clk) begin
		oklch_t want;
		if (arst_n) begin
			if (start && !busy) begin
				color_q.push_back(convert_pixel(pixel));
			end
			if (done) begin
				if (color_q.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = color_q.pop_front();
					if (color.lightness !== want.lightness) begin
						report_mismatch("lightness", color.lightness, want.lightness);
					end
					if (color.chroma !== want.chroma) begin
						report_mismatch("chroma", color.chroma, want.chroma);
					end
					if (color.hue !== want.hue) begin
						report_mismatch("hue", color.hue, want.hue);
					end
				end
			end
		end
	end

endmodule

FILE: tb/srgb_to_oklch_converter_top_test.sv
`timescale 1ns / 1ps

module srgb_to_oklch_converter_top_test import s2ok_pkg::*;;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pixel_t pixel = '0;
	logic done;
	oklch_t color;
	int errors;
	int pending;
	int unsigned cycles = 0;
	int idle_pct = 0;

	srgb_to_oklch_converter_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.done(done),
		.color(color)
	);

	srgb_to_oklch_converter_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.done(done),
		.color(color),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// hold the request until accepted; random gaps before each one
	task automatic send_pixel(pixel_t px);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	task automatic send_random(int n);
		pixel_t px;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: px = {8'($urandom), 8'($urandom), 8'($urandom)};
				1: begin
					px.red = 8'($urandom);
					px.green = px.red;
					px.blue = px.red;
				end
				2: px = {8'($urandom_range(10)), 8'($urandom_range(10)), 8'($urandom_range(10))};
				default: px = {8'($urandom_range(255, 240)), 8'($urandom), 8'($urandom_range(15))};
			endcase
			send_pixel(px);
		end
	endtask

	initial begin
		pixel_t dir [$];
		dir = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
			24'h00FFFF, 24'hFF00FF, 24'h0A0A0A, 24'h0B0B0B, 24'h0A0B0C, 24'h808080,
			24'h010000, 24'h000001, 24'h7F7F7F, 24'hFF8000, 24'h0080FF, 24'h8000FF,
			24'h00FF80, 24'hAA55AA, 24'h55AA55, 24'h0B0A0B};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i]) begin
			send_pixel(dir[i]);
		end
		idle_pct = 21;
		send_random(300);
		idle_pct = 59;
		send_random(300);
		idle_pct = 0;
		send_random(300);
		start <= 1'b0;
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (120) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
